// File: hw/rtl/tmrc_pkg.sv
// ---------------------------------------------------------------------------
// tmrc_pkg - shared types and constants for the tile map collision unit
// Field widths, register indexes, command codes and the controller states.
// ---------------------------------------------------------------------------
`default_nettype none

package tmrc_pkg;

  // elaboration defaults for the top-level parameters
  localparam int MAX_TILES_DEF       = 4096;
  localparam int COORD_FRAC_BITS_DEF = 8;

  // fixed field widths
  localparam int CELL_IDX_W = 12;
  localparam int COORD_W    = 24;
  localparam int SIZE_W     = 23;
  localparam int TILE_DIM_W = 8;
  localparam int MAP_DIM_W  = 7;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 8;

  // largest tile corner in whole pixels: 127 tiles of 255 pixels
  localparam int TILE_PX_W = 15;

  // register reset values
  localparam logic [TILE_DIM_W-1:0] TILE_W_RST = 8'd32;
  localparam logic [TILE_DIM_W-1:0] TILE_H_RST = 8'd32;
  localparam logic [MAP_DIM_W-1:0]  MAP_W_RST  = 7'd64;
  localparam logic [MAP_DIM_W-1:0]  MAP_H_RST  = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TILE_W = 2'd0,
    REG_TILE_H = 2'd1,
    REG_MAP_W  = 2'd2,
    REG_MAP_H  = 2'd3
  } reg_idx_t;

  typedef enum logic {
    CMD_WRITE = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_SCAN  = 2'd2
  } state_t;

endpackage

`default_nettype wire

// File: hw/rtl/tile_map_rect_collision_unit.sv
// ---------------------------------------------------------------------------
// tile_map_rect_collision_unit - rectangle against solid tile map
// One-bit solid map in a synchronous RAM; queries scan it cell by cell.
// ---------------------------------------------------------------------------
//  channel   ports                                         handshake
//  input     in_cmd, in_cell_*, in_rect_*                  start / busy
//  result    out_hit                                       out_valid strobe
//  config    cfg_index, cfg_wdata                          cfg_we
//
//  A cell write's result (hit = 0) appears in the cycle after it is accepted,
//  as does the result of a query on a map with no cells in use.
//  A query without a hit holds busy while it reads min(map_width*map_height,
//  MAX_TILES) cells, one RAM read per cycle, then tests the last cell read and
//  closes the scan. A hit closes it the cycle after that cell is read.
//  The result appears in the same cycle that busy drops. After reset a
//  clearing pass over every RAM cell holds busy high; configuration writes are
//  taken throughout. The receiver cannot stall: out_valid is a one-cycle strobe.
// ---------------------------------------------------------------------------
`default_nettype none

module tile_map_rect_collision_unit
  import tmrc_pkg::*;
#(
  parameter int MAX_TILES       = MAX_TILES_DEF,
  parameter int COORD_FRAC_BITS = COORD_FRAC_BITS_DEF
) (
  input  wire                          clk,
  input  wire                          rst_n,

  input  wire                          start,
  output logic                         busy,
  input  wire                          in_cmd,
  input  wire        [CELL_IDX_W-1:0]  in_cell_index,
  input  wire                          in_cell_solid,
  input  wire signed [COORD_W-1:0]     in_rect_left,
  input  wire signed [COORD_W-1:0]     in_rect_top,
  input  wire        [SIZE_W-1:0]      in_rect_width,
  input  wire        [SIZE_W-1:0]      in_rect_height,

  input  wire                          cfg_we,
  input  wire        [CFG_IDX_W-1:0]   cfg_index,
  input  wire        [CFG_DATA_W-1:0]  cfg_wdata,

  output logic                         out_valid,
  output logic                         out_hit
);

  localparam int AW     = (MAX_TILES > 1) ? $clog2(MAX_TILES) : 1;
  localparam int CNT_W  = $clog2(MAX_TILES + 1);
  localparam int PROD_W = 2 * MAP_DIM_W;
  // signed compare width: rectangle right edge or tile edge in fixed point
  localparam int TILE_FX_W = TILE_PX_W + 2 + COORD_FRAC_BITS;
  localparam int CW = (TILE_FX_W > COORD_W + 1) ? TILE_FX_W : COORD_W + 1;

  // configuration
  logic [TILE_DIM_W-1:0] tile_w_r, tile_h_r;
  logic [MAP_DIM_W-1:0]  map_w_r, map_h_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tile_w_r <= TILE_W_RST;
      tile_h_r <= TILE_H_RST;
      map_w_r  <= MAP_W_RST;
      map_h_r  <= MAP_H_RST;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TILE_W: tile_w_r <= cfg_wdata[TILE_DIM_W-1:0];
        REG_TILE_H: tile_h_r <= cfg_wdata[TILE_DIM_W-1:0];
        REG_MAP_W:  map_w_r  <= cfg_wdata[MAP_DIM_W-1:0];
        REG_MAP_H:  map_h_r  <= cfg_wdata[MAP_DIM_W-1:0];
      endcase
    end
  end

  // control state
  state_t             state_r, state_nxt;
  logic [AW-1:0]      clr_idx_r, clr_idx_nxt;
  logic [CNT_W-1:0]   idx_r, idx_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic [MAP_DIM_W-1:0] col_r, col_nxt, row_r, row_nxt;
  logic [TILE_PX_W-1:0] tl_r, tl_nxt, tt_r, tt_nxt;
  logic               p_valid_r, p_valid_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic               out_hit_r, out_hit_nxt;

  // query payload
  logic signed [CW-1:0] rl_r, rr_r, rt_r, rb_r;
  logic                 rsize_ok_r;
  logic [TILE_PX_W-1:0] p_tl_r, p_tt_r;

  // RAM
  logic              mem [MAX_TILES];
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic              mem_wdata;
  logic [AW-1:0]     rd_addr;
  logic              rd_data_r;

  logic              accept;
  logic              rd_en;
  logic              hit_now;
  logic [PROD_W-1:0] map_prod;
  logic [CNT_W-1:0]  map_count;
  logic              idx_in_range;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign accept       = start && !busy;
  assign map_prod     = PROD_W'(map_w_r) * PROD_W'(map_h_r);
  assign map_count    = (32'(map_prod) > 32'(MAX_TILES)) ? CNT_W'(MAX_TILES)
                                                         : CNT_W'(map_prod);
  assign idx_in_range = 32'(in_cell_index) < 32'(MAX_TILES);
  assign rd_addr      = idx_r[AW-1:0];

  // overlap test of the cell read last cycle; strict on both axes
  logic signed [CW-1:0] tx_lo, tx_hi, ty_lo, ty_hi;
  logic                 x_ok, y_ok;

  always_comb begin
    tx_lo = $signed(CW'(p_tl_r) << COORD_FRAC_BITS);
    tx_hi = $signed((CW'(p_tl_r) + CW'(tile_w_r)) << COORD_FRAC_BITS);
    ty_lo = $signed(CW'(p_tt_r) << COORD_FRAC_BITS);
    ty_hi = $signed((CW'(p_tt_r) + CW'(tile_h_r)) << COORD_FRAC_BITS);
    x_ok  = (tile_w_r != '0) && (tx_lo < rr_r) && (rl_r < tx_hi);
    y_ok  = (tile_h_r != '0) && (ty_lo < rb_r) && (rt_r < ty_hi);
  end

  assign hit_now = p_valid_r && rd_data_r && rsize_ok_r && x_ok && y_ok;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_idx_r   <= '0;
      idx_r       <= '0;
      count_r     <= '0;
      col_r       <= '0;
      row_r       <= '0;
      tl_r        <= '0;
      tt_r        <= '0;
      p_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      out_hit_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_idx_r   <= clr_idx_nxt;
      idx_r       <= idx_nxt;
      count_r     <= count_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      tl_r        <= tl_nxt;
      tt_r        <= tt_nxt;
      p_valid_r   <= p_valid_nxt;
      out_valid_r <= out_valid_nxt;
      out_hit_r   <= out_hit_nxt;
    end
  end

  always_ff @(posedge clk) begin
    p_tl_r <= tl_r;
    p_tt_r <= tt_r;
    if (accept && (cmd_t'(in_cmd) == CMD_QUERY)) begin
      rl_r       <= CW'(in_rect_left);
      rt_r       <= CW'(in_rect_top);
      rr_r       <= $signed(CW'(in_rect_left) + CW'(in_rect_width));
      rb_r       <= $signed(CW'(in_rect_top) + CW'(in_rect_height));
      rsize_ok_r <= (in_rect_width != '0) && (in_rect_height != '0);
    end
  end

  always_comb begin
    state_nxt     = state_r;
    clr_idx_nxt   = clr_idx_r;
    idx_nxt       = idx_r;
    count_nxt     = count_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    tl_nxt        = tl_r;
    tt_nxt        = tt_r;
    out_valid_nxt = 1'b0;
    out_hit_nxt   = 1'b0;
    mem_we        = 1'b0;
    mem_waddr     = clr_idx_r;
    mem_wdata     = 1'b0;
    rd_en         = 1'b0;
    busy          = 1'b1;

    unique case (state_r)
      ST_CLEAR: begin
        mem_we      = 1'b1;
        clr_idx_nxt = clr_idx_r + 1'b1;
        if (clr_idx_r == AW'(MAX_TILES - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          if (cmd_t'(in_cmd) == CMD_WRITE) begin
            mem_we        = idx_in_range;
            mem_waddr     = AW'(in_cell_index);
            mem_wdata     = in_cell_solid;
            out_valid_nxt = 1'b1;
          end else if (map_count == '0) begin
            out_valid_nxt = 1'b1;
          end else begin
            count_nxt = map_count;
            idx_nxt   = '0;
            col_nxt   = '0;
            row_nxt   = '0;
            tl_nxt    = '0;
            tt_nxt    = '0;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        rd_en = (idx_r < count_r) && !hit_now;
        if (rd_en) begin
          idx_nxt = idx_r + 1'b1;
          // step column and row together with their pixel origins
          if (col_r == map_w_r - 1'b1) begin
            col_nxt = '0;
            tl_nxt  = '0;
            row_nxt = row_r + 1'b1;
            tt_nxt  = tt_r + TILE_PX_W'(tile_h_r);
          end else begin
            col_nxt = col_r + 1'b1;
            tl_nxt  = tl_r + TILE_PX_W'(tile_w_r);
          end
        end
        if (hit_now) begin
          out_valid_nxt = 1'b1;
          out_hit_nxt   = 1'b1;
          state_nxt     = ST_IDLE;
        end else if (!rd_en && !p_valid_r) begin
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    p_valid_nxt = rd_en;
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // a result is only ever raised while the unit is idle
  a_result_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy)
    else $error("result strobe while busy");

  a_write_result: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && (in_cmd == CMD_WRITE)) |=> (out_valid && !out_hit))
    else $error("cell write did not give a zero result next cycle");

  a_pipe_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    p_valid_r |-> (state_r == ST_SCAN))
    else $error("read data pending outside a scan");

  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (idx_r <= count_r))
    else $error("scan index ran past cell count");

  a_hit_only_query: assert property (@(posedge clk) disable iff (!rst_n)
    out_hit |-> $past(state_r == ST_SCAN))
    else $error("hit reported without a scan");

endmodule

`default_nettype wire
